### rtl/rpt_pkg.sv
// ----------------------------------------------------------------------------
// rpt_pkg: shared types and constants of the region permission table
// Table depth, slot index widths, operation and status codes, and the
// layout of one stored region entry.
// ----------------------------------------------------------------------------
package rpt_pkg;

    // table depth and derived index widths
    localparam int REGIONS = 16;
    localparam int IDX_W   = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int CNT_W   = IDX_W + 1;

    // payload widths
    localparam int ADDR_W  = 64;
    localparam int PERM_W  = 3;
    localparam int SLOT_W  = 8;
    localparam int STAT_W  = 2;
    localparam int FUNC_W  = 2;

    // stream packing: tdata padded to whole bytes
    localparam int S_DATA_RAW = 2 * ADDR_W + PERM_W;
    localparam int S_DATA_W   = ((S_DATA_RAW + 7) / 8) * 8;
    localparam int M_DATA_RAW = STAT_W + 1 + SLOT_W;
    localparam int M_DATA_W   = ((M_DATA_RAW + 7) / 8) * 8;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CHECK = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] ST_DENIED  = 2'd3;

    // one stored region: start, exclusive end, granted permissions
    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] stop;
        logic [PERM_W-1:0] perms;
    } region_t;

endpackage

### rtl/region_permission_table_unit.sv
// ----------------------------------------------------------------------------
// region_permission_table_unit: table of protected memory regions
// Stores regions (start, size, read/write/execute) and answers add, check
// and clear operations, one result item per input item.
// ----------------------------------------------------------------------------
// Usage
//   s_ channel: one operation per item. s_tuser carries the operation code
//   (add, check, clear); s_tdata carries address, byte count and permissions.
//   m_ channel: one result item per input item, in order, with status,
//   region hit flag and slot index.
//   Add, clear and rejected items pass from acceptance through the
//   execute state to the done state, which loads the output register when
//   it is free. A check scans the region memory one slot per cycle through
//   its single read port, from slot 0 up, and stops at the first matching
//   slot or after the last slot. One item is in work at a time: the next
//   item is accepted only in the idle state, after the result of the last
//   one has been loaded.
//   A finished result sits in the output register while the next item is
//   accepted; a stalled receiver holds back only the hand-off of the next
//   result, and s_tready stays low until that result has moved on.
//   Reset clears the slot valid flags at once, so every slot reads as free
//   right after reset with no clearing pass; a clear item does the same.
// ----------------------------------------------------------------------------
module region_permission_table_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: base_address[63:0], byte_count[127:64], perm_bits[130:128]
    input  logic [rpt_pkg::S_DATA_W-1:0]  s_tdata,
    // s_tuser: func[1:0]
    input  logic [rpt_pkg::FUNC_W-1:0]    s_tuser,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // m_tdata: status[1:0], region_hit[2], slot_index[10:3]
    output logic [rpt_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DONE
    } state_t;

    state_t state_reg;

    // captured item
    logic [rpt_pkg::FUNC_W-1:0] func_reg;
    logic [rpt_pkg::ADDR_W-1:0] base_reg;
    logic [rpt_pkg::ADDR_W-1:0] count_reg;
    logic [rpt_pkg::PERM_W-1:0] perm_reg;
    logic [rpt_pkg::ADDR_W-1:0] end_reg;

    // slot occupancy, cleared at reset and by a clear item
    logic [rpt_pkg::REGIONS-1:0] valid_reg;

    // scan pipeline
    logic [rpt_pkg::CNT_W-1:0]  iss_idx_reg;
    logic                        rd_live_reg;
    logic [rpt_pkg::IDX_W-1:0]  rd_slot_reg;
    rpt_pkg::region_t            rd_word_reg;

    // pending result
    logic [rpt_pkg::STAT_W-1:0] res_status_reg;
    logic                        res_hit_reg;
    logic [rpt_pkg::SLOT_W-1:0] res_slot_reg;

    // output register
    logic                        m_tvalid_reg;
    logic [rpt_pkg::M_DATA_W-1:0] m_tdata_reg;

    // region memory
    rpt_pkg::region_t            mem [rpt_pkg::REGIONS];

    logic [rpt_pkg::ADDR_W:0]    span_sum;
    logic                        span_ok;
    logic                        free_found;
    logic [rpt_pkg::IDX_W-1:0]  free_idx;
    logic                        mem_we;
    rpt_pkg::region_t            mem_wdata;
    logic [rpt_pkg::IDX_W-1:0]  rd_addr;
    logic                        hit_now;
    logic                        scan_last;
    logic                        out_free;
    logic                        s_accept;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // span validation: nonzero start, nonzero size, no wrap past the top
    assign span_sum = {1'b0, base_reg} + {1'b0, count_reg};
    assign span_ok  = (base_reg != '0) && (count_reg != '0) && !span_sum[rpt_pkg::ADDR_W];

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = rpt_pkg::REGIONS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = rpt_pkg::IDX_W'(i);
            end
        end
    end

    // write port: add stores the region in the free slot
    assign mem_we          = (state_reg == S_EXEC) && (func_reg == rpt_pkg::FUNC_ADD)
                             && span_ok && free_found;
    assign mem_wdata.start = base_reg;
    assign mem_wdata.stop  = span_sum[rpt_pkg::ADDR_W-1:0];
    assign mem_wdata.perms = perm_reg;

    assign rd_addr = iss_idx_reg[rpt_pkg::IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[free_idx] <= mem_wdata;
        end
        rd_word_reg <= mem[rd_addr];
    end

    // containment test on the slot read last cycle
    assign hit_now   = rd_live_reg && valid_reg[rd_slot_reg]
                       && (base_reg >= rd_word_reg.start)
                       && (end_reg <= rd_word_reg.stop);
    assign scan_last = rd_live_reg && (rd_slot_reg == rpt_pkg::IDX_W'(rpt_pkg::REGIONS - 1));

    // control and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            rd_live_reg  <= 1'b0;
            iss_idx_reg  <= '0;
        end else begin
            // output handshake, the done state reloads the register itself
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE)) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        func_reg  <= s_tuser;
                        base_reg  <= s_tdata[rpt_pkg::ADDR_W-1:0];
                        count_reg <= s_tdata[2*rpt_pkg::ADDR_W-1:rpt_pkg::ADDR_W];
                        perm_reg  <= s_tdata[2*rpt_pkg::ADDR_W+rpt_pkg::PERM_W-1:
                                             2*rpt_pkg::ADDR_W];
                        state_reg <= S_EXEC;
                    end
                end

                S_EXEC: begin
                    res_status_reg <= rpt_pkg::ST_OK;
                    res_hit_reg    <= 1'b0;
                    res_slot_reg   <= '0;
                    end_reg        <= span_sum[rpt_pkg::ADDR_W-1:0];
                    state_reg      <= S_DONE;
                    unique case (func_reg)
                        rpt_pkg::FUNC_ADD: begin
                            if (!span_ok) begin
                                res_status_reg <= rpt_pkg::ST_INVALID;
                            end else if (!free_found) begin
                                res_status_reg <= rpt_pkg::ST_FULL;
                            end else begin
                                valid_reg[free_idx] <= 1'b1;
                                res_slot_reg        <= rpt_pkg::SLOT_W'(free_idx);
                            end
                        end
                        rpt_pkg::FUNC_CHECK: begin
                            if (!span_ok) begin
                                res_status_reg <= rpt_pkg::ST_INVALID;
                            end else begin
                                iss_idx_reg <= '0;
                                rd_live_reg <= 1'b0;
                                state_reg   <= S_SCAN;
                            end
                        end
                        rpt_pkg::FUNC_CLEAR: begin
                            valid_reg <= '0;
                        end
                        default: begin
                            res_status_reg <= rpt_pkg::ST_INVALID;
                        end
                    endcase
                end

                S_SCAN: begin
                    if (hit_now) begin
                        res_hit_reg    <= 1'b1;
                        res_slot_reg   <= rpt_pkg::SLOT_W'(rd_slot_reg);
                        res_status_reg <= ((perm_reg & ~rd_word_reg.perms) != '0)
                                          ? rpt_pkg::ST_DENIED : rpt_pkg::ST_OK;
                        rd_live_reg    <= 1'b0;
                        state_reg      <= S_DONE;
                    end else if (scan_last) begin
                        rd_live_reg <= 1'b0;
                        state_reg   <= S_DONE;
                    end else begin
                        // issue the next slot read
                        rd_live_reg <= (iss_idx_reg < rpt_pkg::CNT_W'(rpt_pkg::REGIONS));
                        rd_slot_reg <= iss_idx_reg[rpt_pkg::IDX_W-1:0];
                        iss_idx_reg <= iss_idx_reg + rpt_pkg::CNT_W'(1);
                    end
                end

                S_DONE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= rpt_pkg::M_DATA_W'({res_slot_reg, res_hit_reg,
                                                            res_status_reg});
                        state_reg    <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // a clear item leaves every slot free
    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC && func_reg == rpt_pkg::FUNC_CLEAR) |=> (valid_reg == '0))
        else $error("slots still occupied after clear");

    // a successful add occupies exactly one more slot
    a_add_one_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |=> ($countones(valid_reg) == $countones($past(valid_reg)) + 1))
        else $error("add did not occupy exactly one slot");

    // a reported hit always names an occupied slot
    a_hit_is_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE && res_hit_reg)
            |-> valid_reg[res_slot_reg[rpt_pkg::IDX_W-1:0]])
        else $error("hit reported on a free slot");

    // a pending result is never dropped by a new output load
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |=> (m_tvalid_reg && $stable(m_tdata_reg)))
        else $error("stalled result overwritten");

endmodule

### sim/region_permission_table_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// region_permission_table_unit_tb: self-checking bench of the region table
// Drives add, check, clear and unused operations over the s_ stream, keeps
// a shadow copy of the region table to predict every result item, and
// compares each result on the m_ stream field by field, under random
// sender and receiver idling and one long receiver hold-off.
// ----------------------------------------------------------------------------
module region_permission_table_unit_tb;

    localparam logic [rpt_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 400;
    localparam int ITEMS_PER_PHASE = 500;
    localparam logic [rpt_pkg::ADDR_W-1:0] ALL_ONES = '1;

    typedef struct packed {
        logic [rpt_pkg::STAT_W-1:0] status;
        logic                       hit;
        logic [rpt_pkg::SLOT_W-1:0] slot;
    } verdict_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic [rpt_pkg::S_DATA_W-1:0]  s_tdata = '0;
    logic [rpt_pkg::FUNC_W-1:0]    s_tuser = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [rpt_pkg::M_DATA_W-1:0]  m_tdata;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;

    // shadow region table
    logic [rpt_pkg::ADDR_W-1:0] slot_base [rpt_pkg::REGIONS];
    logic [rpt_pkg::ADDR_W-1:0] slot_size [rpt_pkg::REGIONS];
    logic [rpt_pkg::PERM_W-1:0] slot_perms [rpt_pkg::REGIONS];

    verdict_t pending_verdicts[$];
    int mismatch_count = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;

    region_permission_table_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // apply one operation to the shadow table and return its result item
    function automatic verdict_t predict_verdict(logic [rpt_pkg::FUNC_W-1:0] func,
                                                 logic [rpt_pkg::ADDR_W-1:0] base,
                                                 logic [rpt_pkg::ADDR_W-1:0] count,
                                                 logic [rpt_pkg::PERM_W-1:0] perm);
        verdict_t v;
        logic [rpt_pkg::ADDR_W:0] span_end;
        logic span_ok;
        logic found;
        v = '{status: rpt_pkg::ST_OK, hit: 1'b0, slot: '0};
        span_end = {1'b0, base} + {1'b0, count};
        span_ok = (base != 0) && (count != 0) && !span_end[rpt_pkg::ADDR_W];
        found = 1'b0;
        case (func)
            rpt_pkg::FUNC_ADD: begin
                if (!span_ok) begin
                    v.status = rpt_pkg::ST_INVALID;
                end else begin
                    for (int i = 0; i < rpt_pkg::REGIONS; i++) begin
                        if (!found && slot_base[i] == 0) begin
                            found = 1'b1;
                            slot_base[i] = base;
                            slot_size[i] = count;
                            slot_perms[i] = perm;
                            v.slot = rpt_pkg::SLOT_W'(i);
                        end
                    end
                    if (!found) v.status = rpt_pkg::ST_FULL;
                end
            end
            rpt_pkg::FUNC_CHECK: begin
                if (!span_ok) begin
                    v.status = rpt_pkg::ST_INVALID;
                end else begin
                    // first containing region decides
                    for (int i = 0; i < rpt_pkg::REGIONS; i++) begin
                        if (!found && slot_base[i] != 0 && base >= slot_base[i] &&
                            span_end[rpt_pkg::ADDR_W-1:0] <= slot_base[i] + slot_size[i])
                        begin
                            found = 1'b1;
                            v.hit = 1'b1;
                            v.slot = rpt_pkg::SLOT_W'(i);
                            if ((perm & ~slot_perms[i]) != 0) v.status = rpt_pkg::ST_DENIED;
                        end
                    end
                end
            end
            rpt_pkg::FUNC_CLEAR: begin
                for (int i = 0; i < rpt_pkg::REGIONS; i++) begin
                    slot_base[i] = '0;
                    slot_size[i] = '0;
                    slot_perms[i] = '0;
                end
            end
            default: begin
                v.status = rpt_pkg::ST_INVALID;
            end
        endcase
        return v;
    endfunction

    // offer one item, wait for acceptance, record its expected result
    task automatic send_request(logic [rpt_pkg::FUNC_W-1:0] func,
                                logic [rpt_pkg::ADDR_W-1:0] base,
                                logic [rpt_pkg::ADDR_W-1:0] count,
                                logic [rpt_pkg::PERM_W-1:0] perm);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tuser = func;
        s_tdata = {{(rpt_pkg::S_DATA_W - rpt_pkg::S_DATA_RAW){1'b0}}, perm, count, base};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_verdicts.push_back(predict_verdict(func, base, count, perm));
        @(negedge aclk);
    endtask

    // well-formed add with random content, now and then a broken one
    task automatic send_random_add();
        logic [rpt_pkg::ADDR_W-1:0] base;
        logic [rpt_pkg::ADDR_W-1:0] count;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
                base = 64'h1000 + $urandom_range(0, 4095);
                count = $urandom_range(1, 8192);
            end
            5, 6: begin
                base = 64'hFFFF_FFFF_FFFF_0000 + $urandom_range(0, 65535);
                count = $urandom_range(1, 65536);
            end
            7, 8: begin
                base = rand64();
                if (base == 0) base = 1;
                count = (~base == 0) ? 64'd1 : (rand64() % ~base) + 1;
            end
            default: begin
                base = ($urandom_range(1) != 0) ? '0 : rand64();
                count = (base != 0) ? '0 : rand64();
            end
        endcase
        send_request(rpt_pkg::FUNC_ADD, base, count, 3'($urandom_range(7)));
    endtask

    // check mostly inside or around a stored region
    task automatic send_random_check();
        logic [rpt_pkg::ADDR_W-1:0] base;
        logic [rpt_pkg::ADDR_W-1:0] count;
        logic [rpt_pkg::ADDR_W-1:0] offset;
        int first;
        int pick;
        first = $urandom_range(rpt_pkg::REGIONS - 1);
        pick = -1;
        for (int k = 0; k < rpt_pkg::REGIONS; k++) begin
            if (pick < 0 && slot_base[(first + k) % rpt_pkg::REGIONS] != 0) begin
                pick = (first + k) % rpt_pkg::REGIONS;
            end
        end
        if (pick >= 0 && $urandom_range(9) < 8) begin
            offset = rand64() % slot_size[pick];
            base = slot_base[pick] + offset;
            count = (rand64() % (slot_size[pick] - offset)) + 1;
            case ($urandom_range(5))
                0: count = count + 1;
                1: base = base - 1;
                default: ;
            endcase
        end else begin
            base = 64'h1000 + $urandom_range(0, 8191);
            count = $urandom_range(0, 4096);
        end
        send_request(rpt_pkg::FUNC_CHECK, base, count, 3'($urandom_range(7)));
    endtask

    task automatic run_random_items(int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 35) send_random_add();
            else if (r < 80) send_random_check();
            else if (r < 85) send_request(rpt_pkg::FUNC_CLEAR, rand64(), rand64(),
                                          3'($urandom_range(7)));
            else if (r < 90) send_request(FUNC_UNUSED, rand64(), rand64(),
                                          3'($urandom_range(7)));
            else send_request(2'($urandom_range(3)), rand64(), rand64(),
                              3'($urandom_range(7)));
        end
    endtask

    // field extremes, validation, unused selector, clear
    task automatic test_directed_extremes();
        send_request(rpt_pkg::FUNC_CHECK, 64'h1000, 64'h10, 3'b111);
        send_request(rpt_pkg::FUNC_ADD, '0, 64'h100, 3'b111);
        send_request(rpt_pkg::FUNC_ADD, 64'h100, '0, 3'b111);
        send_request(rpt_pkg::FUNC_ADD, ALL_ONES, 64'd1, 3'b111);
        send_request(rpt_pkg::FUNC_ADD, 64'd1, ALL_ONES - 1, 3'b101);
        send_request(rpt_pkg::FUNC_CHECK, ALL_ONES - 1, 64'd1, 3'b010);
        send_request(rpt_pkg::FUNC_CHECK, ALL_ONES - 1, 64'd1, 3'b101);
        send_request(rpt_pkg::FUNC_CHECK, '0, 64'd1, 3'b000);
        send_request(rpt_pkg::FUNC_CHECK, 64'd1, ALL_ONES, 3'b000);
        send_request(FUNC_UNUSED, ALL_ONES, ALL_ONES, 3'b111);
        send_request(rpt_pkg::FUNC_CLEAR, ALL_ONES, ALL_ONES, 3'b111);
        send_request(rpt_pkg::FUNC_CHECK, ALL_ONES - 1, 64'd1, 3'b000);
    endtask

    // fill every slot, overlapping regions, then one add too many
    task automatic test_table_full();
        send_request(rpt_pkg::FUNC_ADD, 64'h10_0000, 64'h1000, 3'b001);
        send_request(rpt_pkg::FUNC_ADD, 64'h10_0000, 64'h1_0000, 3'b111);
        for (int k = 2; k < rpt_pkg::REGIONS; k++) begin
            send_request(rpt_pkg::FUNC_ADD, 64'h20_0000 + k * 64'h1000, 64'h1000, 3'(k));
        end
        send_request(rpt_pkg::FUNC_CHECK, 64'h10_0800, 64'h10, 3'b010);
        send_request(rpt_pkg::FUNC_CHECK, 64'h10_1000, 64'h100, 3'b010);
        send_request(rpt_pkg::FUNC_CHECK, 64'h20_2F00, 64'h200, 3'b000);
        send_request(rpt_pkg::FUNC_ADD, 64'h30_0000, 64'h10, 3'b111);
    endtask

    // receiver holds off while the sender keeps offering items
    task automatic test_backpressure();
        send_idle_pct = 0;
        hold_requests++;
        run_random_items(24);
    endtask

    task automatic test_random_traffic();
        send_idle_pct = 9;
        recv_idle_pct = 52;
        run_random_items(ITEMS_PER_PHASE);
        send_idle_pct = 52;
        recv_idle_pct = 9;
        run_random_items(ITEMS_PER_PHASE);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_items(ITEMS_PER_PHASE);
    endtask

    // receiver: random idling plus long hold-off on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_tready = 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
            m_tready = 1'b0;
        end else begin
            m_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // compare each result item with the oldest expectation
    always @(posedge aclk) begin : result_check
        verdict_t want;
        verdict_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tdata[1:0];
            got.hit = m_tdata[2];
            got.slot = m_tdata[10:3];
            if (pending_verdicts.size() == 0) begin
                $error("result item with nothing expected: %h", m_tdata);
                mismatch_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (got.status != want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    mismatch_count++;
                end
                if (got.hit != want.hit) begin
                    $error("region_hit: expected %0d, actual %0d", want.hit, got.hit);
                    mismatch_count++;
                end
                if (got.slot != want.slot) begin
                    $error("slot_index: expected %0d, actual %0d", want.slot, got.slot);
                    mismatch_count++;
                end
            end
        end
    end

    // main sequence
    initial begin
        int guard;
        for (int i = 0; i < rpt_pkg::REGIONS; i++) begin
            slot_base[i] = '0;
            slot_size[i] = '0;
            slot_perms[i] = '0;
        end
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;
        send_idle_pct = 9;
        recv_idle_pct = 52;
        test_directed_extremes();
        test_table_full();
        test_backpressure();
        test_random_traffic();
        s_tvalid = 1'b0;
        guard = 0;
        while (pending_verdicts.size() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (rpt_pkg::REGIONS + 8) @(posedge aclk);
        if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // run time limit
    initial begin
        #10ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
